### rtl/icmpc_pkg.sv
`default_nettype none

package icmpc_pkg;

   localparam int FIFO_DEPTH      = 4;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [5:0]  MIN_HEADER = 6'd20;
   localparam logic [16:0] MIN_ICMP   = 17'd8;
   localparam logic [15:0] SUM_GOOD   = 16'hFFFF;
   localparam logic [15:0] INDEX_MAX  = 16'hFFFF;

   // byte positions inside the IP header
   localparam logic [15:0] POS_IHL    = 16'd0;
   localparam logic [15:0] POS_LEN_HI = 16'd2;
   localparam logic [15:0] POS_LEN_LO = 16'd3;
   localparam logic [15:0] POS_TTL    = 16'd8;

   // byte offsets inside the ICMP message
   localparam logic [15:0] OFF_TYPE   = 16'd0;
   localparam logic [15:0] OFF_ID_HI  = 16'd4;
   localparam logic [15:0] OFF_ID_LO  = 16'd5;
   localparam logic [15:0] OFF_SEQ_HI = 16'd6;
   localparam logic [15:0] OFF_SEQ_LO = 16'd7;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_ID  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_SEQ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_CHECKSUM = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_TYPE   = 3'd1,
      ACT_ID_HI  = 3'd2,
      ACT_ID_LO  = 3'd3,
      ACT_SEQ_HI = 3'd4,
      ACT_SEQ_LO = 3'd5
   } action_type;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] icmp_len;
      logic [7:0]  ttl_seen;
      logic [15:0] seq_seen;
      logic [15:0] id_seen;
   } rsp_type;

   // one classified byte, from front to back
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        hold_en;
      logic        add_en;
      action_type  action;
      logic        short_pkt;
      logic [15:0] icmp_len;
      logic [7:0]  ttl;
   } entry_type;

   // ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

`default_nettype wire

### rtl/icmpc_front.sv
`default_nettype none

module icmpc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire icmpc_pkg::req_type    req_data,
   input  wire logic                  fifo_full,
   output logic                       push,
   output icmpc_pkg::entry_type       entry
);

   logic [15:0] byte_index_ff, byte_index_in;
   logic [5:0]  hb_ff, hb_in;
   logic [15:0] tl_ff, tl_in;
   logic [7:0]  ttl_ff, ttl_in;

   logic [5:0]  hb_eff;
   logic [15:0] tl_eff;
   logic [7:0]  ttl_eff;
   logic [15:0] hb_ext;
   logic [15:0] off;
   logic [16:0] received;
   logic        in_icmp;
   logic [7:0]  b;

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;
   assign b         = req_data.pkt_byte;

   always_comb begin
      hb_eff  = (byte_index_ff == icmpc_pkg::POS_IHL) ? {b[3:0], 2'b00} : hb_ff;
      tl_eff  = tl_ff;
      if (byte_index_ff == icmpc_pkg::POS_LEN_HI) begin
         tl_eff = {b, tl_ff[7:0]};
      end else if (byte_index_ff == icmpc_pkg::POS_LEN_LO) begin
         tl_eff = {tl_ff[15:8], b};
      end
      ttl_eff  = (byte_index_ff == icmpc_pkg::POS_TTL) ? b : ttl_ff;
      hb_ext   = {10'd0, hb_eff};
      in_icmp  = (byte_index_ff >= hb_ext) && (byte_index_ff < tl_eff);
      off      = byte_index_ff - hb_ext;
      received = {1'b0, byte_index_ff} + 17'd1;

      entry.data     = b;
      entry.last     = req_data.last_byte;
      entry.hold_en  = in_icmp && !off[0];
      entry.add_en   = in_icmp && off[0];
      entry.action   = icmpc_pkg::ACT_NONE;
      if (in_icmp) begin
         unique case (off)
            icmpc_pkg::OFF_TYPE:   entry.action = icmpc_pkg::ACT_TYPE;
            icmpc_pkg::OFF_ID_HI:  entry.action = icmpc_pkg::ACT_ID_HI;
            icmpc_pkg::OFF_ID_LO:  entry.action = icmpc_pkg::ACT_ID_LO;
            icmpc_pkg::OFF_SEQ_HI: entry.action = icmpc_pkg::ACT_SEQ_HI;
            icmpc_pkg::OFF_SEQ_LO: entry.action = icmpc_pkg::ACT_SEQ_LO;
            default:               entry.action = icmpc_pkg::ACT_NONE;
         endcase
      end
      entry.short_pkt = (hb_eff < icmpc_pkg::MIN_HEADER)
                     || ({1'b0, tl_eff} < ({11'd0, hb_eff} + icmpc_pkg::MIN_ICMP))
                     || (received < {1'b0, tl_eff});
      entry.icmp_len  = (tl_eff >= hb_ext) ? (tl_eff - hb_ext) : 16'd0;
      entry.ttl       = ttl_eff;

      byte_index_in = byte_index_ff;
      hb_in         = hb_ff;
      tl_in         = tl_ff;
      ttl_in        = ttl_ff;
      if (push) begin
         if (req_data.last_byte) begin
            byte_index_in = '0;
            hb_in         = '0;
            tl_in         = '0;
            ttl_in        = '0;
         end else begin
            // hold at the top so long packets stay beyond any length
            byte_index_in = (byte_index_ff == icmpc_pkg::INDEX_MAX) ?
                            byte_index_ff : byte_index_ff + 16'd1;
            hb_in         = hb_eff;
            tl_in         = tl_eff;
            ttl_in        = ttl_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         hb_ff         <= '0;
         tl_ff         <= '0;
         ttl_ff        <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         hb_ff         <= hb_in;
         tl_ff         <= tl_in;
         ttl_ff        <= ttl_in;
      end
   end

   a_front_clear: assert property (@(posedge clock) disable iff (reset)
      push && req_data.last_byte |=> byte_index_ff == '0 && tl_ff == '0 && hb_ff == '0)
      else $error("front state not cleared after last byte");

endmodule

`default_nettype wire

### rtl/icmpc_fifo.sv
`default_nettype none

module icmpc_fifo #(
   parameter int DEPTH = icmpc_pkg::FIFO_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire icmpc_pkg::entry_type  wr_entry,
   input  wire logic                  pop,
   output icmpc_pkg::entry_type       rd_entry,
   output logic                       full,
   output logic                       empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   icmpc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop) && !(pop && empty))
      else $error("queue overflow or underflow");

endmodule

`default_nettype wire

### rtl/icmpc_back.sv
`default_nettype none

module icmpc_back (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire icmpc_pkg::entry_type                      entry,
   input  wire logic                                      fifo_empty,
   output logic                                           pop,
   input  wire logic                                      csr_we,
   input  wire logic [icmpc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [icmpc_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output icmpc_pkg::rsp_type                             rsp_data
);

   logic [15:0] sum_ff, sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] exp_id_ff, exp_id_in;
   logic [15:0] exp_seq_ff, exp_seq_in;
   logic        rsp_valid_ff, rsp_valid_in;
   icmpc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        pop_last;
   logic [7:0]  hold_eff;
   logic [7:0]  type_eff;
   logic [15:0] id_eff;
   logic [15:0] seq_eff;
   logic [15:0] word;
   logic [15:0] sum_eff;
   icmpc_pkg::status_type status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = !fifo_empty && (!entry.last || out_free);
   assign pop_last  = pop && entry.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      hold_eff = entry.hold_en ? entry.data : hold_ff;
      type_eff = type_ff;
      id_eff   = id_ff;
      seq_eff  = seq_ff;
      unique case (entry.action)
         icmpc_pkg::ACT_NONE:   ;
         icmpc_pkg::ACT_TYPE:   type_eff = entry.data;
         icmpc_pkg::ACT_ID_HI:  id_eff   = {entry.data, id_ff[7:0]};
         icmpc_pkg::ACT_ID_LO:  id_eff   = {id_ff[15:8], entry.data};
         icmpc_pkg::ACT_SEQ_HI: seq_eff  = {entry.data, seq_ff[7:0]};
         icmpc_pkg::ACT_SEQ_LO: seq_eff  = {seq_ff[15:8], entry.data};
         default:               ;
      endcase

      // one adder serves both the word add and the odd-length pad; the two
      // only meet on a packet that is short anyway
      if (entry.add_en) begin
         word = {hold_ff, entry.data};
      end else if (entry.last && entry.icmp_len[0]) begin
         word = {hold_eff, 8'h00};
      end else begin
         word = 16'h0000;
      end
      sum_eff = icmpc_pkg::oc_add(sum_ff, word);

      if (entry.short_pkt) begin
         status = icmpc_pkg::STATUS_SHORT;
      end else if (sum_eff != icmpc_pkg::SUM_GOOD) begin
         status = icmpc_pkg::STATUS_CHECKSUM;
      end else if (id_eff != exp_id_ff || type_eff != 8'h00 || seq_eff != exp_seq_ff) begin
         status = icmpc_pkg::STATUS_MISMATCH;
      end else begin
         status = icmpc_pkg::STATUS_ACCEPTED;
      end

      sum_in  = sum_ff;
      hold_in = hold_ff;
      type_in = type_ff;
      id_in   = id_ff;
      seq_in  = seq_ff;
      if (pop) begin
         if (entry.last) begin
            sum_in  = '0;
            hold_in = '0;
            type_in = '0;
            id_in   = '0;
            seq_in  = '0;
         end else begin
            sum_in  = sum_eff;
            hold_in = hold_eff;
            type_in = type_eff;
            id_in   = id_eff;
            seq_in  = seq_eff;
         end
      end

      exp_id_in  = exp_id_ff;
      exp_seq_in = exp_seq_ff;
      if (csr_we) begin
         unique case (csr_index)
            icmpc_pkg::CSR_EXPECTED_ID:  exp_id_in  = csr_wdata;
            icmpc_pkg::CSR_EXPECTED_SEQ: exp_seq_in = csr_wdata;
            default:                     ;
         endcase
      end

      rsp_data_in          = rsp_data_ff;
      rsp_data_in.status   = status;
      rsp_data_in.icmp_len = entry.icmp_len;
      rsp_data_in.ttl_seen = entry.ttl;
      rsp_data_in.seq_seen = seq_eff;
      rsp_data_in.id_seen  = id_eff;
      if (!pop_last) begin
         rsp_data_in = rsp_data_ff;
      end

      if (pop_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         hold_ff      <= '0;
         type_ff      <= '0;
         id_ff        <= '0;
         seq_ff       <= '0;
         exp_id_ff    <= '0;
         exp_seq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         hold_ff      <= hold_in;
         type_ff      <= type_in;
         id_ff        <= id_in;
         seq_ff       <= seq_in;
         exp_id_ff    <= exp_id_in;
         exp_seq_ff   <= exp_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_back_slot: assert property (@(posedge clock) disable iff (reset)
      pop_last |-> !rsp_valid_ff || !rsp_stall)
      else $error("result written over a pending transfer");

   a_back_clear: assert property (@(posedge clock) disable iff (reset)
      pop_last |=> sum_ff == '0 && hold_ff == '0 && rsp_valid_ff)
      else $error("back state not cleared or result not raised");

endmodule

`default_nettype wire

### rtl/icmp_echo_reply_checker_core.sv
// Channel  Direction  Payload              Transfer when
// req_     in         pkt_byte, last_byte  req_valid && !req_stall
// rsp_     out        status, icmp_len,    rsp_valid && !rsp_stall
//                     ttl_seen, seq_seen, id_seen
// csr_     in         csr_index, csr_wdata csr_we
//
// One byte per clock is taken while the queue is not full; the front classifies it in the cycle it arrives.
// A packet's last byte goes through the queue, its result through the output register.
// The back pops one queued byte per clock, but a last byte waits on a held result.
// Reset is synchronous and clears all packet state and both expected values.
// req_stall rises only when the FIFO_DEPTH-entry queue is full: a last byte waits
// while an older result is held by rsp_stall, and the bytes behind it fill the queue.
`default_nettype none

module icmp_echo_reply_checker_core #(
   parameter int FIFO_DEPTH = icmpc_pkg::FIFO_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire icmpc_pkg::req_type                    req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output icmpc_pkg::rsp_type                         rsp_data,
   input  wire logic                                  csr_we,
   input  wire logic [icmpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [icmpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   icmpc_pkg::entry_type wr_entry;
   icmpc_pkg::entry_type rd_entry;
   logic push;
   logic pop;
   logic fifo_full;
   logic fifo_empty;

   icmpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fifo_full (fifo_full),
      .push      (push),
      .entry     (wr_entry)
   );

   icmpc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .rd_entry (rd_entry),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   icmpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .entry      (rd_entry),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### tb/sv/tb_icmp_echo_reply_checker_core.sv
`timescale 1ns / 1ps

module tb_icmp_echo_reply_checker_core;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned HDR_MIN       = 20;
   localparam int unsigned ICMP_MIN      = 8;
   localparam int unsigned PHASE_BYTES   = 180;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   icmpc_pkg::req_type                    req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   icmpc_pkg::rsp_type                    rsp_data;
   logic                                  csr_we    = 1'b0;
   logic [icmpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = icmpc_pkg::CSR_EXPECTED_ID;
   logic [icmpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   icmp_echo_reply_checker_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // expected register values and per-packet parse state
   logic [15:0] want_id;
   logic [15:0] want_seq;
   logic [15:0] frame_pos;
   logic [5:0]  hdr_len;
   logic [15:0] tot_len;
   logic [7:0]  ttl_cap;
   logic [15:0] csum;
   logic [7:0]  hi_hold;
   logic [7:0]  type_cap;
   logic [15:0] id_cap;
   logic [15:0] seq_cap;

   icmpc_pkg::rsp_type verdict_q [$];
   icmpc_pkg::req_type pending [$];
   logic [7:0]  frame [$];

   int unsigned pace_mode = 1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_draw;
   int unsigned stim_bytes = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   icmpc_pkg::rsp_type want;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      int unsigned s;
      s = 32'(a) + 32'(b);
      s = (s & 32'hFFFF) + (s >> 16);
      return s[15:0];
   endfunction

   // mostly no gap, some short ones, a few long, none at all while pace_mode is zero
   function automatic int unsigned pick_delay();
      int unsigned r;
      r = $urandom_range(99);
      if (pace_mode == 0 || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   task automatic clear_frame_state();
      frame_pos = '0;
      hdr_len   = '0;
      tot_len   = '0;
      ttl_cap   = '0;
      csum      = '0;
      hi_hold   = '0;
      type_cap  = '0;
      id_cap    = '0;
      seq_cap   = '0;
   endtask

   // advance the parser by one transferred byte, queue the verdict on the last one
   task automatic echo_check_byte(input icmpc_pkg::req_type it);
      int unsigned idx;
      int unsigned off;
      int unsigned rcvd;
      int unsigned ilen;
      logic [15:0] fold;
      icmpc_pkg::rsp_type v;
      idx = 32'(frame_pos);
      if (idx == 0)
         hdr_len = {it.pkt_byte[3:0], 2'b00};
      else if (idx == 2)
         tot_len[15:8] = it.pkt_byte;
      else if (idx == 3)
         tot_len[7:0] = it.pkt_byte;
      else if (idx == 8)
         ttl_cap = it.pkt_byte;
      if (idx >= 32'(hdr_len) && idx < 32'(tot_len)) begin
         off = idx - 32'(hdr_len);
         case (off)
            0: type_cap = it.pkt_byte;
            4: id_cap[15:8] = it.pkt_byte;
            5: id_cap[7:0] = it.pkt_byte;
            6: seq_cap[15:8] = it.pkt_byte;
            7: seq_cap[7:0] = it.pkt_byte;
            default: ;
         endcase
         if (off[0] == 1'b0)
            hi_hold = it.pkt_byte;
         else
            csum = ones_add(csum, {hi_hold, it.pkt_byte});
      end
      if (frame_pos != 16'hFFFF)
         frame_pos = frame_pos + 16'd1;
      if (it.last_byte) begin
         rcvd = idx + 1;
         ilen = (tot_len >= 16'(hdr_len)) ? 32'(tot_len) - 32'(hdr_len) : 0;
         fold = csum;
         if (ilen[0])
            fold = ones_add(fold, {hi_hold, 8'h00});
         if (32'(hdr_len) < HDR_MIN || 32'(tot_len) < 32'(hdr_len) + ICMP_MIN ||
             rcvd < 32'(tot_len))
            v.status = icmpc_pkg::STATUS_SHORT;
         else if (fold != 16'hFFFF)
            v.status = icmpc_pkg::STATUS_CHECKSUM;
         else if (id_cap != want_id || type_cap != 8'h00 || seq_cap != want_seq)
            v.status = icmpc_pkg::STATUS_MISMATCH;
         else
            v.status = icmpc_pkg::STATUS_ACCEPTED;
         v.icmp_len = ilen[15:0];
         v.ttl_seen = ttl_cap;
         v.seq_seen = seq_cap;
         v.id_seen  = id_cap;
         verdict_q.push_back(v);
         clear_frame_state();
      end
   endtask

   // driver: one transfer per free slot, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall)
            echo_check_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               req_data  <= pending.pop_front();
               req_valid <= 1'b1;
               gap_left  <= pick_delay();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each transfer against the oldest verdict, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: status %0d len %0d ttl %0d seq %h id %h",
                           rsp_data.status, rsp_data.icmp_len, rsp_data.ttl_seen,
                           rsp_data.seq_seen, rsp_data.id_seen);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.icmp_len !== want.icmp_len ||
                   rsp_data.ttl_seen !== want.ttl_seen ||
                   rsp_data.seq_seen !== want.seq_seen ||
                   rsp_data.id_seen !== want.id_seen) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch: status %0d/%0d len %0d/%0d ttl %0d/%0d ",
                               "seq %h/%h id %h/%h (expected/actual)"},
                              want.status, rsp_data.status, want.icmp_len, rsp_data.icmp_len,
                              want.ttl_seen, rsp_data.ttl_seen, want.seq_seen,
                              rsp_data.seq_seen, want.id_seen, rsp_data.id_seen);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            stall_draw = pick_delay();
            rsp_stall  <= (stall_draw != 0);
            stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[icmp_echo_reply_checker_core] ERROR");
         $finish;
      end
   end

   task automatic write_csr(input logic [icmpc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == icmpc_pkg::CSR_EXPECTED_ID)
         want_id = val;
      else
         want_seq = val;
   endtask

   task automatic poke(input int unsigned pos, input logic [7:0] val);
      if (pos < frame.size())
         frame[pos] = val;
   endtask

   // IPv4 header plus ICMP echo message with a correct checksum, optionally one bit flipped
   task automatic build_frame(input int unsigned ihl, input int unsigned icmp_n,
                              input logic [7:0] icmp_type, input logic [15:0] icmp_id,
                              input logic [15:0] echo_seq, input logic [7:0] ttl,
                              input bit corrupt);
      int unsigned hdr;
      int unsigned total;
      int unsigned k;
      logic [15:0] acc;
      hdr   = ihl * 4;
      total = hdr + icmp_n;
      frame.delete();
      for (k = 0; k < total; k++)
         frame.push_back(8'($urandom_range(255)));
      poke(hdr, icmp_type);
      poke(hdr + 2, 8'h00);
      poke(hdr + 3, 8'h00);
      poke(hdr + 4, icmp_id[15:8]);
      poke(hdr + 5, icmp_id[7:0]);
      poke(hdr + 6, echo_seq[15:8]);
      poke(hdr + 7, echo_seq[7:0]);
      acc = '0;
      for (k = hdr; k < total; k += 2)
         acc = ones_add(acc, {frame[k], (k + 1 < total) ? frame[k + 1] : 8'h00});
      acc = ~acc;
      poke(hdr + 2, acc[15:8]);
      poke(hdr + 3, acc[7:0]);
      if (corrupt && icmp_n != 0) begin
         k = hdr + $urandom_range(icmp_n - 1);
         frame[k] = frame[k] ^ (8'h01 << $urandom_range(7));
      end
      // header fields go last so a tiny header cannot clobber them
      poke(0, {4'h4, ihl[3:0]});
      poke(2, total[15:8]);
      poke(3, total[7:0]);
      poke(8, ttl);
   endtask

   task automatic set_total(input logic [15:0] val);
      poke(2, val[15:8]);
      poke(3, val[7:0]);
   endtask

   task automatic trim_frame(input int unsigned n);
      repeat (n)
         if (frame.size() > 1)
            void'(frame.pop_back());
   endtask

   task automatic pad_frame(input int unsigned n);
      repeat (n)
         frame.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_frame();
      icmpc_pkg::req_type it;
      int unsigned k;
      if (frame.size() == 0)
         frame.push_back(8'($urandom_range(255)));
      for (k = 0; k < frame.size(); k++) begin
         it.pkt_byte  = frame[k];
         it.last_byte = (k == frame.size() - 1);
         pending.push_back(it);
      end
      stim_bytes += frame.size();
   endtask

   // hold until every byte is in and every verdict is out, then let the back settle
   task automatic drain();
      @(negedge clock);
      while (pending.size() != 0 || req_valid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_packet();
      int unsigned kind;
      int unsigned ihl;
      int unsigned n;
      int unsigned k;
      logic [15:0] pid;
      logic [15:0] pseq;
      logic [7:0]  ptype;
      kind  = $urandom_range(99);
      ihl   = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
      n     = ($urandom_range(3) == 0) ? ICMP_MIN : $urandom_range(48, ICMP_MIN);
      pid   = want_id;
      pseq  = want_seq;
      ptype = 8'h00;
      if (kind >= 55 && kind < 63) begin
         case ($urandom_range(2))
            0: pid = pid ^ (16'h0001 << $urandom_range(15));
            1: pseq = pseq ^ (16'h0001 << $urandom_range(15));
            default: ptype = 8'($urandom_range(255, 1));
         endcase
      end
      if (kind >= 90 && kind < 94) begin
         ihl = $urandom_range(4);
         n   = $urandom_range(40, 4);
      end
      build_frame(ihl, n, ptype, pid, pseq, 8'($urandom_range(255)),
                  kind >= 63 && kind < 71);
      if (kind >= 71 && kind < 79) begin
         trim_frame($urandom_range(frame.size() - 1, 1));
      end else if (kind >= 79 && kind < 85) begin
         pad_frame($urandom_range(10, 1));
      end else if (kind >= 85 && kind < 90) begin
         set_total(16'($urandom_range(ihl * 4 + ICMP_MIN - 1)));
      end else if (kind >= 94) begin
         frame.delete();
         for (k = $urandom_range(40, 1); k != 0; k--)
            frame.push_back(8'($urandom_range(255)));
      end
      send_frame();
   endtask

   int unsigned phase;

   initial begin
      want_id  = '0;
      want_seq = '0;
      clear_frame_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed packets against the reset values of both registers
      build_frame(5, 8, 8'h00, want_id, want_seq, 8'h40, 0);
      send_frame();
      build_frame(5, 9, 8'h00, want_id, want_seq, 8'hFF, 0);   // odd length, zero pad
      send_frame();
      build_frame(15, 8, 8'h00, want_id, want_seq, 8'h00, 0);  // longest header
      send_frame();
      build_frame(5, 12, 8'h00, want_id, want_seq, 8'h11, 1);  // bad checksum
      send_frame();
      build_frame(5, 8, 8'h08, want_id, want_seq, 8'h22, 0);   // echo request type
      send_frame();
      build_frame(5, 8, 8'h00, 16'hFFFF, want_seq, 8'h33, 0);
      send_frame();
      build_frame(5, 8, 8'h00, want_id, 16'h0001, 8'h44, 0);
      send_frame();
      build_frame(4, 12, 8'h00, want_id, want_seq, 8'h55, 0);  // header under 20 bytes
      send_frame();
      build_frame(0, 8, 8'h00, want_id, want_seq, 8'h66, 0);
      send_frame();
      build_frame(5, 7, 8'h00, want_id, want_seq, 8'h77, 0);   // ICMP part under 8 bytes
      send_frame();
      build_frame(5, 10, 8'h00, want_id, want_seq, 8'h88, 0);  // total below header
      set_total(16'd12);
      send_frame();
      build_frame(5, 16, 8'h00, want_id, want_seq, 8'h99, 0);  // cut before total length
      trim_frame(5);
      send_frame();
      build_frame(5, 8, 8'h00, want_id, want_seq, 8'hAA, 0);   // ends before the length field
      trim_frame(frame.size() - 2);
      send_frame();
      frame.delete();
      frame.push_back(8'h45);
      send_frame();
      build_frame(5, 10, 8'h00, want_id, want_seq, 8'hBB, 0);  // trailing bytes
      pad_frame(6);
      send_frame();
      build_frame(5, 20, 8'h00, want_id, want_seq, 8'hCC, 0);  // longest total, cut short
      set_total(16'hFFFF);
      send_frame();
      drain();

      write_csr(icmpc_pkg::CSR_EXPECTED_ID, 16'hA5C3);
      write_csr(icmpc_pkg::CSR_EXPECTED_SEQ, 16'hFFFF);
      pace_mode = 0;
      build_frame(5, 8, 8'h00, want_id, want_seq, 8'h80, 0);
      send_frame();
      build_frame(5, 11, 8'h00, want_id, want_seq, 8'h81, 0);
      send_frame();
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(icmpc_pkg::CSR_EXPECTED_ID, 16'hFFFF);
               write_csr(icmpc_pkg::CSR_EXPECTED_SEQ, 16'h0000);
            end
            1: begin
               write_csr(icmpc_pkg::CSR_EXPECTED_ID, 16'h0000);
               write_csr(icmpc_pkg::CSR_EXPECTED_SEQ, 16'hFFFF);
            end
            3: begin
               write_csr(icmpc_pkg::CSR_EXPECTED_ID, 16'hFFFF);
               write_csr(icmpc_pkg::CSR_EXPECTED_SEQ, 16'hFFFF);
            end
            default: begin
               write_csr(icmpc_pkg::CSR_EXPECTED_ID, 16'($urandom_range(16'hFFFF)));
               write_csr(icmpc_pkg::CSR_EXPECTED_SEQ, 16'($urandom_range(16'hFFFF)));
            end
         endcase
         pace_mode  = (phase == 2) ? 0 : 1;
         stim_bytes = 0;
         while (stim_bytes < PHASE_BYTES)
            random_packet();
         drain();
      end

      if (error_count == 0 && verdict_q.size() == 0)
         $display("[icmp_echo_reply_checker_core] OK");
      else
         $display("[icmp_echo_reply_checker_core] ERROR");
      $finish;
   end

endmodule

### files.f
rtl/icmpc_pkg.sv
rtl/icmpc_front.sv
rtl/icmpc_fifo.sv
rtl/icmpc_back.sv
rtl/icmp_echo_reply_checker_core.sv
tb/sv/tb_icmp_echo_reply_checker_core.sv
